// File: rtl/rsl_pkg.sv
// ----------------------------------------------------------------------------
// rsl_pkg
// shared types, constants and helpers of the rtp sequence loss monitor
// ----------------------------------------------------------------------------
package rsl_pkg;

	localparam int unsigned BitmapWords     = 1024;
	localparam int unsigned WordIdxW        = 10;
	localparam int unsigned InitialInterval = 128;
	localparam logic [31:0] PeriodReset     = 32'd450000;
	localparam logic [16:0] IntervalLimit   = 17'd16384;
	localparam logic [30:0] Max31           = 31'h7FFF_FFFF;
	localparam logic [62:0] Max63           = 63'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_MARK,
		ST_RD,
		ST_CHK,
		ST_SW_RD,
		ST_SW_LOAD,
		ST_SW_SCAN,
		ST_SW_END,
		ST_RPT,
		ST_OUT
	} st_t;

	typedef struct packed {
		logic [6:0] ones;
		logic [6:0] run;
	} scan_res_t;

	function automatic logic [30:0] add31(input logic [30:0] a, input logic [30:0] b);
		logic [31:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[31] ? Max31 : s[30:0];
	endfunction

	function automatic logic [62:0] add63(input logic [62:0] a, input logic [62:0] b);
		logic [63:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[63] ? Max63 : s[62:0];
	endfunction

endpackage

// File: rtl/rtp_sequence_loss_monitor.sv
// ----------------------------------------------------------------------------
// rtp_sequence_loss_monitor
// rtp packet loss statistics over a 65536-bit seen bitmap
// ----------------------------------------------------------------------------
// Each input beat is one packet (sequence number, timestamp). After reset the
// block runs a clearing pass over the 1024-word bitmap memory with s_tready
// low; cfg writes are taken at any time. A packet then passes an accept step,
// the bit-serial divider that finds the packet's interval block, for the first
// packet a pre-mark step per word from the base up to its own word, the bitmap
// read-modify-write, the report decision and, with a report, a load step.
// When a packet moves the window, the sweep reads each swept word from memory
// and runs it through the byte-serial scanner, at most 1024 words, then closes
// with an end step. A report beat waits in the output register; the next
// packet is taken meanwhile, and only a second report stalls until the first
// is taken.
module rtp_sequence_loss_monitor #(
	parameter int unsigned INITIAL_INTERVAL = rsl_pkg::InitialInterval
) (
	input  logic         clk,
	input  logic         arst_n,
	// report period register
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	// packet beats
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,   // sequence_number[15:0], media_timestamp[47:16]
	// report beats
	output logic         m_tvalid,
	input  logic         m_tready,
	// window_received, window_expected, longest_loss, reordered_count,
	// max_reorder_distance, duplicate_count, total_received, total_expected,
	// interval_after, one zero pad bit on top
	output logic [287:0] m_tdata
);
	import rsl_pkg::*;

	// bitmap memory
	logic [63:0]           mem [BitmapWords];
	logic [WordIdxW-1:0]   mem_addr;
	logic                  mem_we;
	logic [63:0]           mem_wdata;
	logic [63:0]           rd_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		rd_q <= mem[mem_addr];
	end

	st_t state_q, state_d;

	logic [WordIdxW-1:0] clr_idx_q;
	logic [15:0]  seq_q;
	logic [31:0]  ts_q;
	logic         started_q;
	logic [15:0]  base_q, prev_q, until_q, pos_q;
	logic [13:0]  interval_q;
	logic [30:0]  win_rcv_q, win_exp_q, reo_q, dup_q;
	logic [62:0]  cum_rcv_q, cum_exp_q;
	logic [31:0]  last_q, period_q;
	logic [6:0]   run_q;
	logic [15:0]  peak_q;
	logic [WordIdxW-1:0] mark_w_q;
	logic [WordIdxW:0]   n_q;
	logic [16:0]  got_q, exp_q;
	logic         m_tvalid_q;
	logic [287:0] out_q;

	// shared units
	logic        div_start, div_done;
	logic [13:0] div_rem;
	logic        scan_start, scan_done;
	scan_res_t   scan_res;

	rsl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (s_tdata[15:0]),
		.divisor  (interval_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	rsl_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.word   (rd_q),
		.done   (scan_done),
		.res    (scan_res)
	);

	// per-packet datapath terms
	logic [15:0] floor_w;
	logic [63:0] bit_v, above_m, mark_m;
	logic [5:0]  mark_lo;
	logic [6:0]  mark_hi;
	logic [15:0] dist_w, fold_w;
	logic        sweep_go, reorder_hit, dup_hit, rpt_go, out_free;
	logic [16:0] nv_w;
	logic [13:0] iv_new;

	assign floor_w = seq_q - {2'b00, div_rem};
	assign bit_v   = 64'd1 << seq_q[5:0];
	// bits strictly above the packet's position
	assign above_m = ({64{1'b1}} << seq_q[5:0]) << 1;
	assign reorder_hit = (rd_q & above_m) != 64'd0;
	assign dup_hit     = (rd_q & bit_v) != 64'd0;
	assign fold_w = (seq_q - prev_q);

	// pre-mark mask: bits from the base up to, not including, the packet
	assign mark_lo = (mark_w_q == base_q[15:6]) ? base_q[5:0] : 6'd0;
	assign mark_hi = (mark_w_q == seq_q[15:6]) ? {1'b0, seq_q[5:0]} : 7'd64;
	assign mark_m  = ({64{1'b1}} << mark_lo) & ~({64{1'b1}} << mark_hi);

	assign dist_w   = seq_q - base_q;
	assign sweep_go = (dist_w >= {1'b0, interval_q, 1'b0}) && !dist_w[15];

	assign rpt_go   = ((ts_q - last_q) > period_q) && (win_exp_q != 31'd0);
	assign out_free = !m_tvalid_q || m_tready;

	// interval adaptation from the reorder peak, rounded up to 64
	assign nv_w   = ({1'b0, peak_q} + 17'd63) & ~17'd63;
	assign iv_new = ((peak_q >= {2'b00, interval_q}) && (nv_w < IntervalLimit))
		? nv_w[13:0] : interval_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:   if (clr_idx_q == {WordIdxW{1'b1}}) state_d = ST_IDLE;
			ST_IDLE:    if (s_tvalid) state_d = ST_DIV;
			ST_DIV:     if (div_done) state_d = started_q ? ST_RD : ST_MARK;
			ST_MARK:    if (mark_w_q == seq_q[15:6]) state_d = ST_RD;
			ST_RD:      state_d = ST_CHK;
			ST_CHK:     state_d = sweep_go ? ST_SW_RD : ST_RPT;
			ST_SW_RD:   state_d = ((pos_q == until_q) || n_q[WordIdxW]) ? ST_SW_END
				: ST_SW_LOAD;
			ST_SW_LOAD: state_d = ST_SW_SCAN;
			ST_SW_SCAN: if (scan_done) state_d = ST_SW_RD;
			ST_SW_END:  state_d = ST_RPT;
			ST_RPT:     state_d = rpt_go ? ST_OUT : ST_IDLE;
			ST_OUT:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// memory and unit controls
	always_comb begin
		mem_addr   = seq_q[15:6];
		mem_we     = 1'b0;
		mem_wdata  = 64'd0;
		div_start  = 1'b0;
		scan_start = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_addr = clr_idx_q;
				mem_we   = 1'b1;
			end
			ST_IDLE:  div_start = s_tvalid;
			ST_MARK: begin
				mem_addr  = mark_w_q;
				mem_we    = 1'b1;
				mem_wdata = mark_m;
			end
			ST_CHK: begin
				mem_we    = 1'b1;
				mem_wdata = rd_q | bit_v;
			end
			ST_SW_RD:   mem_addr = pos_q[15:6];
			ST_SW_LOAD: scan_start = 1'b1;
			ST_SW_SCAN: begin
				mem_addr = pos_q[15:6];
				mem_we   = scan_done;
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_idx_q  <= '0;
			seq_q      <= '0;
			ts_q       <= '0;
			started_q  <= 1'b0;
			base_q     <= '0;
			prev_q     <= '0;
			until_q    <= '0;
			pos_q      <= '0;
			interval_q <= INITIAL_INTERVAL[13:0];
			win_rcv_q  <= '0;
			win_exp_q  <= '0;
			cum_rcv_q  <= '0;
			cum_exp_q  <= '0;
			last_q     <= '0;
			period_q   <= PeriodReset;
			run_q      <= '0;
			reo_q      <= '0;
			peak_q     <= '0;
			dup_q      <= '0;
			mark_w_q   <= '0;
			n_q        <= '0;
			got_q      <= '0;
			exp_q      <= '0;
			m_tvalid_q <= 1'b0;
			out_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				period_q <= cfg_wdata;
			// a new report loads when no beat is pending or as the pending beat leaves
			if (state_q == ST_OUT && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_CLEAR: clr_idx_q <= clr_idx_q + WordIdxW'(1);
				ST_IDLE: begin
					if (s_tvalid) begin
						seq_q <= s_tdata[15:0];
						ts_q  <= s_tdata[47:16];
					end
				end
				ST_DIV: begin
					if (div_done) begin
						until_q <= floor_w - {2'b00, interval_q};
						if (!started_q) begin
							// first packet: base at its interval block
							started_q <= 1'b1;
							base_q    <= floor_w;
							prev_q    <= seq_q - 16'd1;
							mark_w_q  <= floor_w[15:6];
						end
					end
				end
				ST_MARK: mark_w_q <= mark_w_q + WordIdxW'(1);
				ST_CHK: begin
					if (reorder_hit) begin
						reo_q <= add31(reo_q, 31'd1);
						if ((fold_w[15] ? (16'd0 - fold_w) : fold_w) > peak_q)
							peak_q <= fold_w[15] ? (16'd0 - fold_w) : fold_w;
					end
					if (dup_hit)
						dup_q <= add31(dup_q, 31'd1);
					prev_q <= seq_q;
					if (sweep_go) begin
						pos_q <= base_q;
						n_q   <= '0;
						got_q <= '0;
						exp_q <= '0;
					end
				end
				ST_SW_SCAN: begin
					if (scan_done) begin
						win_exp_q <= add31(win_exp_q, 31'd64);
						win_rcv_q <= add31(win_rcv_q, {24'd0, scan_res.ones});
						got_q     <= got_q + {10'd0, scan_res.ones};
						exp_q     <= exp_q + 17'd64;
						if (scan_res.run > run_q)
							run_q <= scan_res.run;
						pos_q <= pos_q + 16'd64;
						n_q   <= n_q + (WordIdxW + 1)'(1);
					end
				end
				ST_SW_END: begin
					cum_rcv_q <= add63(cum_rcv_q, {46'd0, got_q});
					cum_exp_q <= add63(cum_exp_q, {46'd0, exp_q});
					base_q    <= until_q;
				end
				ST_OUT: begin
					if (out_free) begin
						out_q <= {1'b0, iv_new, cum_exp_q, cum_rcv_q, dup_q, peak_q,
							reo_q, run_q, win_exp_q, win_rcv_q};
						interval_q <= iv_new;
						win_rcv_q  <= '0;
						win_exp_q  <= '0;
						last_q     <= ts_q;
						run_q      <= '0;
						reo_q      <= '0;
						peak_q     <= '0;
						dup_q      <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	// the divider only finishes while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider result outside the divide step");

	// scanner results only arrive during the sweep scan step
	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> state_q == ST_SW_SCAN)
		else $error("scanner result outside the sweep");

	// a report is only loaded once the previous beat has left
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && m_tvalid_q && !m_tready) |=> $stable(out_q))
		else $error("pending report overwritten");

	// adapted interval never drops below one word
	a_interval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> interval_q >= 14'd64)
		else $error("interval below one word");
endmodule

// File: rtl/rsl_div.sv
// ----------------------------------------------------------------------------
// rsl_div
// restoring divider, one quotient bit per cycle, gives the remainder
// ----------------------------------------------------------------------------
module rsl_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [13:0] divisor,
	output logic        done,
	output logic [13:0] rem
);
	logic [15:0] dvd_q;
	logic [13:0] rem_q;
	logic [13:0] dsr_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [14:0] trial;
	logic [14:0] diff;

	assign trial = {rem_q, dvd_q[15]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 4'd0);
			if (start) begin
				dvd_q  <= dividend;
				dsr_q  <= divisor;
				rem_q  <= '0;
				cnt_q  <= 4'd15;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// keep the partial remainder below the divisor
				rem_q <= (trial >= {1'b0, dsr_q}) ? diff[13:0] : trial[13:0];
				dvd_q <= {dvd_q[14:0], 1'b0};
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0)
					busy_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

// File: rtl/rsl_scan.sv
// ----------------------------------------------------------------------------
// rsl_scan
// word scanner, one byte per cycle: ones count and longest zero run
// ----------------------------------------------------------------------------
module rsl_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [63:0]           word,
	output logic                  done,
	output rsl_pkg::scan_res_t    res
);
	import rsl_pkg::*;

	logic [63:0] sh_q;
	logic [2:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [6:0]  cur_q, best_q, ones_q;
	logic [6:0]  cur_d, best_d, ones_d;

	always_comb begin
		cur_d  = cur_q;
		best_d = best_q;
		ones_d = ones_q;
		for (int i = 0; i < 8; i++) begin
			if (sh_q[i]) begin
				cur_d  = '0;
				ones_d = ones_d + 7'd1;
			end else begin
				cur_d = cur_d + 7'd1;
				if (cur_d > best_d)
					best_d = cur_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			sh_q   <= '0;
			cur_q  <= '0;
			best_q <= '0;
			ones_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 3'd7);
			if (start) begin
				sh_q   <= word;
				cnt_q  <= '0;
				cur_q  <= '0;
				best_q <= '0;
				ones_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				sh_q   <= {8'd0, sh_q[63:8]};
				cur_q  <= cur_d;
				best_q <= best_d;
				ones_q <= ones_d;
				cnt_q  <= cnt_q + 3'd1;
				if (cnt_q == 3'd7)
					busy_q <= 1'b0;
			end
		end
	end

	assign done     = done_q;
	assign res.ones = ones_q;
	assign res.run  = best_q;
endmodule
